// ===== hdl/frequency_ordered_lookup_table_core_defines.svh =====
// ----------------------------------------------------------------------------
// Frequency-ordered lookup table: assertion macros
// Shared property macros for the table core. They compile to nothing in
// synthesis builds.
// ----------------------------------------------------------------------------
`ifndef FREQUENCY_ORDERED_LOOKUP_TABLE_CORE_DEFINES_SVH
`define FREQUENCY_ORDERED_LOOKUP_TABLE_CORE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define FOLT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frequency ordered lookup table: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define FOLT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frequency ordered lookup table: next-cycle check failed");

`else

`define FOLT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FOLT_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/folt_pkg.sv =====
// ----------------------------------------------------------------------------
// Frequency-ordered lookup table package
// Widths, result codes, beat types and the sequencer state type.
// ----------------------------------------------------------------------------
package folt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int VALUE_W         = 32;
    localparam int COUNT_W         = 16;
    localparam int POS_W           = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_ACCESS = 1'b1;

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_MISS     = 2'd1,
        ST_APPENDED = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic                      mode;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] access_count;
    } t_out_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [COUNT_W-1:0]        count;
    } t_entry;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_MOVE   = 5'b00100,
        S_PLACE  = 5'b01000,
        S_REPLY  = 5'b10000
    } t_state;

endpackage

// ===== hdl/frequency_ordered_lookup_table_core.sv =====
// ----------------------------------------------------------------------------
// Frequency-ordered lookup table core
// Ordered table of signed values with access counts. Appends go to the tail;
// a hit bumps the count and moves the entry to the front of its tie group.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | beat
//  --------+-----------+---------------------------+------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//
// Append, full and empty-table beats go straight from idle to the reply state.
// An access scans from the front; a hit then shifts entries back to place it,
// and a miss replies after the last stored entry. The single read port of the
// table RAM reads one entry per cycle, in the scan and then in the shift.
// Reset empties the table at once; no clearing pass is needed.
// A stalled output holds the block in its reply state until the beat leaves.
`include "frequency_ordered_lookup_table_core_defines.svh"

module frequency_ordered_lookup_table_core #(
    parameter int TABLE_DEPTH = folt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  folt_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output folt_pkg::t_out_item o_out_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int TOT_W = $clog2(TABLE_DEPTH + 1);
    localparam int EXT_W = (IDX_W > folt_pkg::POS_W) ? IDX_W : folt_pkg::POS_W;

    folt_pkg::t_state    r_state, n_state;
    logic [TOT_W-1:0]    r_total, n_total;
    logic [TOT_W-1:0]    r_scan, n_scan;
    logic                r_pend, n_pend;
    logic [IDX_W-1:0]    r_pend_idx, n_pend_idx;
    logic [IDX_W-1:0]    r_hole, n_hole;
    logic signed [folt_pkg::VALUE_W-1:0] r_value, n_value;
    logic [folt_pkg::COUNT_W-1:0]        r_cnt, n_cnt;
    folt_pkg::t_out_item r_res, n_res;
    logic                r_out_valid;
    folt_pkg::t_out_item r_out_data;

    logic                w_ram_we;
    logic [IDX_W-1:0]    w_ram_waddr;
    folt_pkg::t_entry    w_ram_wdata;
    logic                w_ram_re;
    logic [IDX_W-1:0]    w_ram_raddr;
    folt_pkg::t_entry    w_rd_data;

    logic                w_match;
    logic                w_last;
    logic                w_shift;
    logic                w_out_free;
    logic [IDX_W-1:0]    w_k;
    logic [folt_pkg::COUNT_W-1:0] w_inc;
    folt_pkg::t_entry    w_new;

    function automatic logic [folt_pkg::POS_W-1:0] f_pos(input logic [IDX_W-1:0] idx);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(idx);
        return ext[folt_pkg::POS_W-1:0];
    endfunction

    folt_ram #(
        .WIDTH ($bits(folt_pkg::t_entry)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (w_ram_waddr),
        .i_wr_data (w_ram_wdata),
        .i_rd_en   (w_ram_re),
        .i_rd_addr (w_ram_raddr),
        .o_rd_data (w_rd_data)
    );

    assign w_match    = r_pend && (w_rd_data.value == r_value);
    assign w_last     = ((TOT_W'(r_pend_idx) + TOT_W'(1)) == r_total);
    assign w_inc      = (w_rd_data.count == folt_pkg::COUNT_MAX)
                        ? w_rd_data.count
                        : w_rd_data.count + folt_pkg::COUNT_W'(1);
    assign w_k        = r_hole - IDX_W'(1);
    assign w_shift    = (w_rd_data.count <= r_cnt);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_new      = '{value: r_value, count: r_cnt};

    assign o_in_stall  = (r_state != folt_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_scan      = r_scan;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_hole      = r_hole;
        n_value     = r_value;
        n_cnt       = r_cnt;
        n_res       = r_res;
        w_ram_we    = 1'b0;
        w_ram_waddr = '0;
        w_ram_wdata = '0;
        w_ram_re    = 1'b0;
        w_ram_raddr = '0;

        case (r_state)
            folt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = folt_pkg::S_REPLY;
                    n_value = i_in_data.value;
                    if (i_in_data.mode == folt_pkg::MODE_APPEND) begin
                        if (r_total == TOT_W'(TABLE_DEPTH)) begin
                            n_res = '{status: folt_pkg::ST_FULL, position: '0,
                                      access_count: '0};
                        end else begin
                            w_ram_we    = 1'b1;
                            w_ram_waddr = r_total[IDX_W-1:0];
                            w_ram_wdata = '{value: i_in_data.value,
                                            count: folt_pkg::COUNT_W'(1)};
                            n_total     = r_total + TOT_W'(1);
                            n_res = '{status: folt_pkg::ST_APPENDED,
                                      position: f_pos(r_total[IDX_W-1:0]),
                                      access_count: folt_pkg::COUNT_W'(1)};
                        end
                    end else if (r_total == '0) begin
                        n_res = '{status: folt_pkg::ST_MISS, position: '0,
                                  access_count: '0};
                    end else begin
                        // Start the scan at the front; data returns next cycle.
                        w_ram_re   = 1'b1;
                        w_ram_raddr = '0;
                        n_pend     = 1'b1;
                        n_pend_idx = '0;
                        n_scan     = TOT_W'(1);
                        n_state    = folt_pkg::S_SEARCH;
                    end
                end
            end
            folt_pkg::S_SEARCH: begin
                if (w_match) begin
                    n_cnt  = w_inc;
                    n_hole = r_pend_idx;
                    n_pend = 1'b0;
                    if (r_pend_idx == '0) begin
                        n_state = folt_pkg::S_PLACE;
                    end else begin
                        w_ram_re    = 1'b1;
                        w_ram_raddr = r_pend_idx - IDX_W'(1);
                        n_state     = folt_pkg::S_MOVE;
                    end
                end else if (r_pend && w_last) begin
                    n_pend  = 1'b0;
                    n_res   = '{status: folt_pkg::ST_MISS, position: '0,
                                access_count: '0};
                    n_state = folt_pkg::S_REPLY;
                end else begin
                    n_pend = (r_scan < r_total);
                    if (r_scan < r_total) begin
                        w_ram_re    = 1'b1;
                        w_ram_raddr = r_scan[IDX_W-1:0];
                        n_pend_idx  = r_scan[IDX_W-1:0];
                        n_scan      = r_scan + TOT_W'(1);
                    end
                end
            end
            folt_pkg::S_MOVE: begin
                // Read data is the entry just ahead of the hole. It drops back
                // into the hole unless its count is larger than the new count.
                w_ram_we    = 1'b1;
                w_ram_waddr = r_hole;
                if (w_shift) begin
                    w_ram_wdata = w_rd_data;
                    n_hole      = w_k;
                    if (w_k == '0) begin
                        n_state = folt_pkg::S_PLACE;
                    end else begin
                        w_ram_re    = 1'b1;
                        w_ram_raddr = w_k - IDX_W'(1);
                    end
                end else begin
                    w_ram_wdata = w_new;
                    n_res = '{status: folt_pkg::ST_HIT, position: f_pos(r_hole),
                              access_count: r_cnt};
                    n_state = folt_pkg::S_REPLY;
                end
            end
            folt_pkg::S_PLACE: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_hole;
                w_ram_wdata = w_new;
                n_res = '{status: folt_pkg::ST_HIT, position: f_pos(r_hole),
                          access_count: r_cnt};
                n_state = folt_pkg::S_REPLY;
            end
            folt_pkg::S_REPLY: begin
                if (w_out_free) begin
                    n_state = folt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = folt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= folt_pkg::S_IDLE;
            r_total     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_pend  <= n_pend;
            if (r_state == folt_pkg::S_REPLY && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan     <= n_scan;
        r_pend_idx <= n_pend_idx;
        r_hole     <= n_hole;
        r_value    <= n_value;
        r_cnt      <= n_cnt;
        r_res      <= n_res;
        if (r_state == folt_pkg::S_REPLY && w_out_free) begin
            r_out_data <= r_res;
        end
    end

    `FOLT_ASSERT_IMP(a_total_in_range, i_clk, i_rst_n, 1'b1, r_total <= TOT_W'(TABLE_DEPTH))
    `FOLT_ASSERT_IMP(a_no_rw_collision, i_clk, i_rst_n, w_ram_we && w_ram_re, w_ram_waddr != w_ram_raddr)
    `FOLT_ASSERT_IMP(a_hit_has_count, i_clk, i_rst_n, o_out_valid && o_out_data.status == folt_pkg::ST_HIT, o_out_data.access_count != '0)
    `FOLT_ASSERT_IMP(a_miss_full_zero, i_clk, i_rst_n, o_out_valid && (o_out_data.status == folt_pkg::ST_MISS || o_out_data.status == folt_pkg::ST_FULL), o_out_data.position == '0 && o_out_data.access_count == '0)
    `FOLT_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

endmodule

// ===== hdl/folt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module folt_ram #(
    parameter int WIDTH = $bits(folt_pkg::t_entry),
    parameter int DEPTH = folt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the frequency-ordered lookup table core
// Drives append and access beats into the core, predicts each result with a
// behavioral copy of the table, and compares every output beat field by field.
// Covers the empty and full table, duplicates, misses, count ties, and random
// traffic with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import folt_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_BEATS = 1000;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AFTER_A = 100;
    localparam int HOLD_AFTER_B = 1000;
    localparam int MAX_REPORTS  = 40;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    // Idle percentages per traffic phase: sender busy, receiver busy, no idling.
    int tx_idle_pct [3] = '{24, 56, 0};
    int rx_idle_pct [3] = '{56, 24, 0};

    typedef struct {
        t_in_item beat;
        int       phase;
        bit       drain_first;
    } t_pending;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    t_pending                  pending_q [$];
    t_out_item                 expected_q [$];
    logic signed [VALUE_W-1:0] stored_q [$];

    // Behavioral copy of the table.
    logic signed [VALUE_W-1:0] tbl_value [TABLE_DEPTH_DEF];
    logic [COUNT_W-1:0]        tbl_count [TABLE_DEPTH_DEF];
    int                        tbl_used = 0;

    int n_total    = 0;
    int n_accepted = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int n_cycles   = 0;
    int cur_phase  = 0;
    int hold_left  = 0;

    frequency_ordered_lookup_table_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Applies one beat to the table copy and returns the result it must produce.
    function automatic t_out_item table_apply(input t_in_item beat);
        t_out_item          res;
        int                 hit;
        int                 dest;
        logic [COUNT_W-1:0] cnt;
        res.status       = ST_MISS;
        res.position     = '0;
        res.access_count = '0;
        if (beat.mode == MODE_APPEND) begin
            if (tbl_used >= TABLE_DEPTH_DEF) begin
                res.status = ST_FULL;
            end else begin
                tbl_value[tbl_used] = beat.value;
                tbl_count[tbl_used] = COUNT_W'(1);
                res.status       = ST_APPENDED;
                res.position     = POS_W'(tbl_used);
                res.access_count = COUNT_W'(1);
                tbl_used++;
            end
            return res;
        end
        hit = 0;
        while (hit < tbl_used && tbl_value[hit] != beat.value)
            hit++;
        if (hit == tbl_used)
            return res;
        cnt = tbl_count[hit];
        if (cnt != COUNT_MAX)
            cnt = cnt + COUNT_W'(1);
        // The entry lands in front of every earlier entry whose count does
        // not exceed its new count.
        dest = hit;
        while (dest > 0 && tbl_count[dest-1] <= cnt)
            dest--;
        for (int k = hit; k > dest; k--) begin
            tbl_value[k] = tbl_value[k-1];
            tbl_count[k] = tbl_count[k-1];
        end
        tbl_value[dest]  = beat.value;
        tbl_count[dest]  = cnt;
        res.status       = ST_HIT;
        res.position     = POS_W'(dest);
        res.access_count = cnt;
        return res;
    endfunction

    task automatic queue_beat(input logic mode, input logic signed [VALUE_W-1:0] value,
                              input int phase, input bit drain_first);
        t_pending p;
        p.beat.mode   = mode;
        p.beat.value  = value;
        p.phase       = phase;
        p.drain_first = drain_first;
        pending_q.push_back(p);
        if (mode == MODE_APPEND && stored_q.size() < TABLE_DEPTH_DEF)
            stored_q.push_back(value);
    endtask

    // Stimulus and end of run.
    initial begin
        int roll;
        int phase;
        int pick;

        // Directed part: empty table, extremes, ties, duplicates, then full.
        queue_beat(MODE_ACCESS, 32'sd0, 0, 1'b0);
        queue_beat(MODE_APPEND, VALUE_MIN, 0, 1'b0);
        queue_beat(MODE_APPEND, VALUE_MAX, 0, 1'b0);
        queue_beat(MODE_APPEND, 32'sd0, 0, 1'b0);
        queue_beat(MODE_APPEND, -32'sd1, 0, 1'b0);
        queue_beat(MODE_APPEND, 32'sd1, 0, 1'b0);
        queue_beat(MODE_ACCESS, VALUE_MAX, 0, 1'b0);
        queue_beat(MODE_ACCESS, VALUE_MIN, 0, 1'b0);
        queue_beat(MODE_ACCESS, 32'sd1, 0, 1'b0);
        queue_beat(MODE_APPEND, -32'sd1, 0, 1'b0);
        queue_beat(MODE_ACCESS, -32'sd1, 0, 1'b0);
        queue_beat(MODE_ACCESS, 32'sd12345, 0, 1'b0);
        queue_beat(MODE_APPEND, 32'sh5555_5555, 0, 1'b0);
        queue_beat(MODE_APPEND, 32'shAAAA_AAAA, 0, 1'b0);
        while (stored_q.size() < TABLE_DEPTH_DEF)
            queue_beat(MODE_APPEND, $urandom, 0, 1'b0);
        queue_beat(MODE_APPEND, 32'sd7, 0, 1'b0);

        // Random part on the full table. A few hot values build up count ties.
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            phase = (n < 400) ? 0 : (n < 800) ? 1 : 2;
            roll  = $urandom_range(0, 99);
            if (roll < 10) begin
                queue_beat(MODE_APPEND, $urandom, phase, n == 0);
            end else if (roll < 20) begin
                queue_beat(MODE_ACCESS, $urandom, phase, n == 0);
            end else begin
                pick = (roll < 55) ? $urandom_range(0, 3) : $urandom_range(0, 15);
                queue_beat(MODE_ACCESS, stored_q[pick], phase, n == 0);
            end
        end

        n_total = pending_q.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (n_checked != n_total)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("frequency_ordered_lookup_table_core test passed");
        end else begin
            $display("frequency_ordered_lookup_table_core test failed");
        end
        $finish;
    end

    always @(posedge clk) begin : beat_driver
        bit       send;
        bit       leaving;
        t_pending next_beat;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                expected_q.push_back(table_apply(in_data));
                n_accepted++;
            end
            // A stalled beat stays on the bus unchanged.
            if (!in_valid || !in_stall) begin
                send    = 1'b0;
                leaving = out_valid && !out_stall;
                if (pending_q.size() != 0) begin
                    if (pending_q[0].drain_first && n_accepted != n_checked + int'(leaving))
                        send = 1'b0;
                    else if ($urandom_range(0, 99) >= tx_idle_pct[pending_q[0].phase])
                        send = 1'b1;
                end
                if (send) begin
                    next_beat = pending_q.pop_front();
                    in_data   <= next_beat.beat;
                    cur_phase <= next_beat.phase;
                end
                in_valid <= send;
            end
        end
    end

    always @(posedge clk) begin : result_monitor
        t_out_item want;
        bit        stall_next;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: result with nothing expected: status=%0d pos=%0d count=%0d",
                                 $time, out_data.status, out_data.position,
                                 out_data.access_count);
                end else begin
                    want = expected_q.pop_front();
                    if (out_data.status !== want.status || out_data.position !== want.position
                        || out_data.access_count !== want.access_count) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("%0t: mismatch: expected status=%0d pos=%0d count=%0d, %s",
                                     $time, want.status, want.position, want.access_count,
                                     $sformatf("actual status=%0d pos=%0d count=%0d",
                                               out_data.status, out_data.position,
                                               out_data.access_count));
                    end
                end
                // Hold the output off for a long stretch so the core backs up.
                if (n_checked + 1 == HOLD_AFTER_A || n_checked + 1 == HOLD_AFTER_B)
                    hold_left = LONG_HOLD;
                n_checked <= n_checked + 1;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else begin
                stall_next = $urandom_range(0, 99) < rx_idle_pct[cur_phase];
            end
            out_stall <= stall_next;
        end
    end

    always @(posedge clk) begin : watchdog
        n_cycles++;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("frequency_ordered_lookup_table_core test failed");
            $finish;
        end
    end

endmodule

// ===== frequency_ordered_lookup_table_core.f =====
+incdir+hdl
hdl/folt_pkg.sv
hdl/folt_ram.sv
hdl/frequency_ordered_lookup_table_core.sv
sim/tb_top.sv
